// ===== rtl/brf_pkg.sv =====
// Shared types and constants for the byte ring FIFO with search.
package brf_pkg;

  localparam int BRF_MAX_SLOTS_DEF    = 64;
  localparam int BRF_RING_SLOTS_RESET = 64;
  localparam int BRF_KIND_W           = 3;
  localparam int BRF_BYTE_W           = 8;
  localparam int BRF_OFF_W            = 6;
  localparam int BRF_CFG_W            = 7;

  typedef enum logic [BRF_KIND_W-1:0] {
    KIND_PUSH  = 3'd0,
    KIND_POP   = 3'd1,
    KIND_PEEK  = 3'd2,
    KIND_DROP  = 3'd3,
    KIND_FIND  = 3'd4,
    KIND_CLEAR = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic exec_op;
    logic take_read;
    logic scan_step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_read;
    logic scan_start;
    logic scan_hit;
    logic scan_last;
  } status_t;

endpackage

// ===== rtl/brf_if.sv =====
// Channel interfaces: request in, result out, slot-count configuration write.
interface brf_item_if
  import brf_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [BRF_KIND_W-1:0] kind;
  logic [BRF_BYTE_W-1:0] data_byte;
  logic [BRF_OFF_W-1:0]  offset;

  modport source (output valid, kind, data_byte, offset, input ready);
  modport sink   (input valid, kind, data_byte, offset, output ready);
endinterface

interface brf_result_if
  import brf_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [BRF_BYTE_W-1:0] read_byte;
  logic                  ok;
  logic [BRF_OFF_W-1:0]  found_offset;
  logic [BRF_OFF_W-1:0]  fill_count;
  logic                  is_empty;
  logic                  is_full;

  modport source (output valid, read_byte, ok, found_offset, fill_count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, read_byte, ok, found_offset, fill_count, is_empty, is_full,
                  output ready);
endinterface

interface brf_cfg_if
  import brf_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [BRF_CFG_W-1:0] ring_slots;

  modport source (output valid, ring_slots, input ready);
  modport sink   (input valid, ring_slots, output ready);
endinterface

// ===== rtl/brf_ctrl.sv =====
// Sequencing state machine for the byte ring FIFO.
module brf_ctrl
  import brf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  output logic    result_valid,
  input  logic    result_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.needs_read)      state_next = ST_READ;
        else if (status.scan_start) state_next = ST_SCAN;
        else                        state_next = ST_DONE;
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (status.scan_hit || status.scan_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (result_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item_ready    = 1'b0;
    result_valid  = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        item_ready    = 1'b1;
        cmd.load_item = item_valid;
      end
      ST_EXEC: begin
        cmd.exec_op = 1'b1;
      end
      ST_READ: begin
        cmd.take_read = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_DONE: begin
        result_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/brf_dp.sv =====
// Ring storage, pointers, fill count and result registers.
module brf_dp
  import brf_pkg::*;
#(
  parameter int MAX_SLOTS = BRF_MAX_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [BRF_CFG_W-1:0]  cfg_slots,
  input  logic [BRF_KIND_W-1:0] in_kind,
  input  logic [BRF_BYTE_W-1:0] in_byte,
  input  logic [BRF_OFF_W-1:0]  in_off,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic [BRF_BYTE_W-1:0] read_byte,
  output logic                  ok,
  output logic [BRF_OFF_W-1:0]  found_offset,
  output logic [BRF_OFF_W-1:0]  fill_count,
  output logic                  is_empty,
  output logic                  is_full
);

  localparam int PTR_W = $clog2(MAX_SLOTS);
  localparam int SW    = $clog2(MAX_SLOTS + 1);
  localparam int AW    = ((SW > BRF_OFF_W) ? SW : BRF_OFF_W) + 1;
  localparam int CW    = ((SW > BRF_CFG_W) ? SW : BRF_CFG_W) + 1;
  localparam int RESET_SLOTS =
    (BRF_RING_SLOTS_RESET > MAX_SLOTS) ? MAX_SLOTS : BRF_RING_SLOTS_RESET;

  logic [BRF_BYTE_W-1:0] mem [MAX_SLOTS];
  logic [BRF_BYTE_W-1:0] mem_q;

  logic [SW-1:0]         slots;
  logic [PTR_W-1:0]      head, tail;
  logic [SW-1:0]         fill;

  logic [BRF_KIND_W-1:0] op_kind;
  logic [BRF_BYTE_W-1:0] op_byte;
  logic [BRF_OFF_W-1:0]  op_off;

  logic [SW-1:0]         scan_idx;
  logic [PTR_W-1:0]      scan_ptr;

  logic [BRF_BYTE_W-1:0] res_byte;
  logic                  res_ok;
  logic [BRF_OFF_W-1:0]  res_fo;

  logic [AW-1:0]         fill_w, off_w, drop_n;
  logic                  peek_ok, is_full_i;
  logic [PTR_W-1:0]      rd_addr;
  logic                  rd_en;
  logic [CW-1:0]         cfg_w, cfg_clamped;
  kind_t                 kind;

  // pointer + n, n below slots
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                input logic [AW-1:0]    n,
                                                input logic [SW-1:0]    s);
    logic [AW-1:0] sum;
    sum = AW'(p) + n;
    if (sum >= AW'(s)) sum = sum - AW'(s);
    return PTR_W'(sum);
  endfunction

  assign kind      = kind_t'(op_kind);
  assign fill_w    = AW'(fill);
  assign off_w     = AW'(op_off);
  assign peek_ok   = off_w < fill_w;
  assign drop_n    = (off_w > fill_w) ? fill_w : off_w;
  assign is_full_i = fill == (slots - SW'(1));

  assign status.needs_read = ((kind == KIND_POP) && (fill != '0)) ||
                             ((kind == KIND_PEEK) && peek_ok);
  assign status.scan_start = (kind == KIND_FIND) && (fill != '0);
  assign status.scan_hit   = mem_q == op_byte;
  assign status.scan_last  = (AW'(scan_idx) + AW'(1)) == fill_w;

  assign cfg_w       = CW'(cfg_slots);
  assign cfg_clamped = (cfg_w < CW'(2)) ? CW'(2) :
                       (cfg_w > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : cfg_w;

  // read address: head for pop/find, head+offset for peek, walker during scan
  always_comb begin
    rd_en   = cmd.exec_op || cmd.scan_step;
    rd_addr = head;
    if (cmd.scan_step) begin
      rd_addr = scan_ptr;
    end else if (kind == KIND_PEEK) begin
      rd_addr = wrap_add(head, off_w, slots);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_op && (kind == KIND_PUSH) && !is_full_i) mem[tail] <= op_byte;
  end

  // ring control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= SW'(RESET_SLOTS);
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else if (cfg_we) begin
      slots <= SW'(cfg_clamped);
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else if (cmd.exec_op) begin
      case (kind)
        KIND_PUSH: begin
          if (!is_full_i) begin
            tail <= wrap_add(tail, AW'(1), slots);
            fill <= fill + SW'(1);
          end
        end
        KIND_POP: begin
          if (fill != '0) begin
            head <= wrap_add(head, AW'(1), slots);
            fill <= fill - SW'(1);
          end
        end
        KIND_DROP: begin
          head <= wrap_add(head, drop_n, slots);
          fill <= fill - SW'(drop_n);
        end
        KIND_CLEAR: begin
          head <= '0;
          tail <= '0;
          fill <= '0;
        end
        default: begin
          fill <= fill;
        end
      endcase
    end
  end

  // request latch, scan walker and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_kind <= in_kind;
      op_byte <= in_byte;
      op_off  <= in_off;
    end
    if (cmd.exec_op) begin
      res_byte <= '0;
      res_fo   <= '0;
      scan_idx <= '0;
      scan_ptr <= wrap_add(head, AW'(1), slots);
      case (kind)
        KIND_PUSH:  res_ok <= !is_full_i;
        KIND_POP:   res_ok <= fill != '0;
        KIND_PEEK:  res_ok <= peek_ok;
        KIND_DROP:  res_ok <= 1'b1;
        KIND_CLEAR: res_ok <= 1'b1;
        default:    res_ok <= 1'b0;
      endcase
    end
    if (cmd.take_read) res_byte <= mem_q;
    if (cmd.scan_step) begin
      if (status.scan_hit) begin
        res_ok <= 1'b1;
        res_fo <= BRF_OFF_W'(scan_idx);
      end else begin
        scan_idx <= scan_idx + SW'(1);
        scan_ptr <= wrap_add(scan_ptr, AW'(1), slots);
      end
    end
  end

  assign read_byte    = res_byte;
  assign ok           = res_ok;
  assign found_offset = res_fo;
  assign fill_count   = fill_w[BRF_OFF_W-1:0];
  assign is_empty     = fill == '0;
  assign is_full      = is_full_i;

  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    AW'(head) < AW'(slots) && AW'(tail) < AW'(slots))
    else $error("ring pointer outside the active slots");

  a_fill_below_cap: assert property (@(posedge clk) disable iff (rst)
    fill < slots)
    else $error("fill count reached the slot count");

  a_tail_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    wrap_add(head, fill_w, slots) == tail)
    else $error("tail does not equal head plus fill");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> AW'(scan_idx) < fill_w)
    else $error("search walked past the stored bytes");

endmodule

// ===== rtl/byte_ring_fifo_with_search_core.sv =====
// Top level of the byte ring FIFO with search: controller plus datapath.
//
// Channels: "item" carries one request (kind, data_byte, offset) with a
// valid/ready handshake; "result" returns exactly one result per request
// (read_byte, ok, found_offset, fill_count, is_empty, is_full); "cfg" writes
// the ring slot count (clamped to 2..MAX_SLOTS) and empties the ring.
// cfg is always ready; write it only while no request is in flight.
//
// Sequence from request accept: push, drop, clear, peek miss, pop on empty
//   and find on empty go through EXEC to DONE; pop and peek hit add READ
//   (one registered read of the ring memory); find adds SCAN, which steps
//   once per byte up to the hit, or over the fill count on a miss; the ring
//   memory's single read port gives one byte per cycle.
// One request is in flight at a time; the next is taken the cycle after the
// result is consumed. A stalled receiver simply holds the result registers
// and the input stays not ready.
// Reset (rst, synchronous) empties the ring and sets the slot count to its
// default; ring memory contents are not cleared and need no sweep.
module byte_ring_fifo_with_search_core
  import brf_pkg::*;
#(
  parameter int MAX_SLOTS = BRF_MAX_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  brf_item_if.sink     item,
  brf_result_if.source result,
  brf_cfg_if.sink      cfg
);

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  // config writes land immediately; only legal while idle
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  brf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  brf_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_slots    (cfg.ring_slots),
    .in_kind      (item.kind),
    .in_byte      (item.data_byte),
    .in_off       (item.offset),
    .cmd          (cmd),
    .status       (status),
    .read_byte    (result.read_byte),
    .ok           (result.ok),
    .found_offset (result.found_offset),
    .fill_count   (result.fill_count),
    .is_empty     (result.is_empty),
    .is_full      (result.is_full)
  );

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the byte ring FIFO with search: request stream checked against a ring predictor.
module tb_top;
  import brf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Kinds the block must answer with ok=0 and no state change.
  localparam logic [BRF_KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [BRF_KIND_W-1:0] KIND_RSVD7 = 3'd7;

  localparam int MIN_SLOTS     = 2;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off, done once
  localparam int SETTLE_CYCLES = 80;   // longer than the worst find (a scan over 63 bytes)
  localparam int MAX_SHOWN     = 10;
  // Worst case per request: a full find, the longest receiver stall and the
  // longest sender gap; over ~2000 requests at 12 ns a clock that is under 5 ms.
  localparam int unsigned TIMEOUT_NS = 25_000_000;
  localparam int PLAN_LEN = 12;

  // One result as the block reports it.
  typedef struct packed {
    logic [BRF_BYTE_W-1:0] read_byte;
    logic                  ok;
    logic [BRF_OFF_W-1:0]  found_offset;
    logic [BRF_OFF_W-1:0]  fill_count;
    logic                  is_empty;
    logic                  is_full;
  } fifo_reply_t;

  // One row of the directed script: either a slot-count write or a request
  // whose reply is written out by hand.
  typedef struct {
    bit                    is_cfg;
    logic [BRF_CFG_W-1:0]  slots;
    logic [BRF_KIND_W-1:0] kind;
    logic [BRF_BYTE_W-1:0] data;
    logic [BRF_OFF_W-1:0]  offs;
    fifo_reply_t           want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  brf_item_if   item_ch ();
  brf_result_if res_ch ();
  brf_cfg_if    cfg_ch ();

  byte_ring_fifo_with_search_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Ring predictor: own copy of slot count, pointers and byte store.
  // ---------------------------------------------------------------------
  logic [BRF_BYTE_W-1:0] ring_mem [BRF_MAX_SLOTS_DEF];
  logic [BRF_CFG_W-1:0]  ring_cfg;
  int                    ring_head;
  int                    ring_tail;

  fifo_reply_t pending_replies [$];  // replies owed by the block, oldest first

  int fails        = 0;
  int replies_seen = 0;
  int cfg_writes   = 0;
  int finds_hit    = 0;
  int deepest_find = 0;
  int full_seen    = 0;
  bit hold_wanted  = 1'b0;
  bit hold_done    = 1'b0;

  // Register value as the ring uses it: clamped to 2..MAX_SLOTS.
  function automatic int ring_slots_eff();
    if (ring_cfg < MIN_SLOTS) return MIN_SLOTS;
    if (ring_cfg > BRF_MAX_SLOTS_DEF) return BRF_MAX_SLOTS_DEF;
    return int'(ring_cfg);
  endfunction

  function automatic int ring_fill(input int s);
    if (ring_tail >= ring_head) return ring_tail - ring_head;
    return s - ring_head + ring_tail;
  endfunction

  // Applies one request to the predicted ring, returns the reply it owes.
  function automatic fifo_reply_t ring_apply(input logic [BRF_KIND_W-1:0] k,
                                             input logic [BRF_BYTE_W-1:0] d,
                                             input logic [BRF_OFF_W-1:0]  o);
    fifo_reply_t r;
    int s, cap, fill, n;
    s    = ring_slots_eff();
    cap  = s - 1;
    r    = '0;
    fill = ring_fill(s);
    case (k)
      KIND_PUSH: begin
        if (fill < cap) begin
          ring_mem[ring_tail] = d;
          ring_tail = (ring_tail + 1) % s;
          r.ok = 1'b1;
        end
      end
      KIND_POP: begin
        if (fill != 0) begin
          r.read_byte = ring_mem[ring_head];
          ring_head = (ring_head + 1) % s;
          r.ok = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (int'(o) < fill) begin
          r.read_byte = ring_mem[(ring_head + int'(o)) % s];
          r.ok = 1'b1;
        end
      end
      KIND_DROP: begin
        // count clamps to what is stored
        n = (int'(o) > fill) ? fill : int'(o);
        ring_head = (ring_head + n) % s;
        r.ok = 1'b1;
      end
      KIND_FIND: begin
        for (int i = 0; i < fill; i++) begin
          if (ring_mem[(ring_head + i) % s] == d) begin
            r.ok = 1'b1;
            r.found_offset = BRF_OFF_W'(i);
            break;
          end
        end
      end
      KIND_CLEAR: begin
        ring_head = 0;
        ring_tail = 0;
        r.ok = 1'b1;
      end
      default: ;  // reserved kinds: status only
    endcase
    fill = ring_fill(s);
    r.fill_count = BRF_OFF_W'(fill);
    r.is_empty   = (fill == 0);
    r.is_full    = (fill == cap);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Helpers for the directed script and random shaping.
  // ---------------------------------------------------------------------
  function automatic fifo_reply_t reply(input logic [7:0] rd, input bit ok,
                                        input logic [5:0] fo, input logic [5:0] fill,
                                        input bit empty, input bit full);
    return {rd, ok, fo, fill, empty, full};
  endfunction

  function automatic script_row_t op_row(input logic [2:0] k, input logic [7:0] d,
                                         input logic [5:0] o, input fifo_reply_t want);
    script_row_t row;
    row = '{is_cfg: 1'b0, slots: '0, kind: k, data: d, offs: o, want: want};
    return row;
  endfunction

  function automatic script_row_t cfg_row(input logic [6:0] v);
    script_row_t row;
    row = '{is_cfg: 1'b1, slots: v, kind: KIND_PUSH, data: '0, offs: '0, want: '0};
    return row;
  endfunction

  // Gap length for either side: mostly none or short, a few long, and now
  // and then a calm stretch with no gaps at all.
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(50, 200);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Picks the next request from the predicted ring. Pushes steer the fill
  // toward target_fill, so the ring spends time near empty, in the middle
  // and at capacity. Peek offsets and find bytes mostly aim at stored bytes.
  function automatic void pick_request(input int target_fill,
                                       output logic [BRF_KIND_W-1:0] k,
                                       output logic [BRF_BYTE_W-1:0] d,
                                       output logic [BRF_OFF_W-1:0]  o);
    logic [BRF_BYTE_W-1:0] motifs [4];
    int s, fill, r, pos;
    motifs = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    s    = ring_slots_eff();
    fill = ring_fill(s);
    d    = BRF_BYTE_W'($urandom_range(0, 255));
    o    = BRF_OFF_W'($urandom_range(0, 63));
    if ($urandom_range(0, 99) < ((fill < target_fill) ? 80 : 15)) begin
      k = KIND_PUSH;
      // a few repeated values make find's first-match rule matter
      if ($urandom_range(0, 3) == 0) d = motifs[$urandom_range(0, 3)];
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 25) k = KIND_POP;
    else if (r < 50) begin
      k = KIND_PEEK;
      if (fill > 0 && $urandom_range(0, 4) != 0) o = BRF_OFF_W'($urandom_range(0, fill - 1));
    end else if (r < 78) begin
      k = KIND_FIND;
      if (fill > 0 && $urandom_range(0, 9) < 7) begin
        pos = ($urandom_range(0, 4) == 0) ? fill - 1 : $urandom_range(0, fill - 1);
        d = ring_mem[(ring_head + pos) % s];
      end
    end else if (r < 93) begin
      k = KIND_DROP;
      if ($urandom_range(0, 4) != 0) o = BRF_OFF_W'($urandom_range(0, 3));
    end else if (r < 96) k = KIND_CLEAR;
    else k = ($urandom_range(0, 1) == 0) ? KIND_RSVD6 : KIND_RSVD7;
  endfunction

  // ---------------------------------------------------------------------
  // Request and configuration drivers.
  // ---------------------------------------------------------------------

  // Offers one request and waits for it to be taken; valid stays high so a
  // back-to-back request follows without a bubble.
  task automatic send_request(input logic [BRF_KIND_W-1:0] k,
                              input logic [BRF_BYTE_W-1:0] d,
                              input logic [BRF_OFF_W-1:0]  o,
                              input bit typed, input fifo_reply_t want);
    fifo_reply_t r;
    item_ch.valid     <= 1'b1;
    item_ch.kind      <= k;
    item_ch.data_byte <= d;
    item_ch.offset    <= o;
    do @(posedge clk); while (!item_ch.ready);
    r = ring_apply(k, d, o);
    if (k == KIND_FIND && r.ok) begin
      finds_hit++;
      if (int'(r.found_offset) > deepest_find) deepest_find = int'(r.found_offset);
    end
    if (r.is_full) full_seen++;
    pending_replies.push_back(typed ? want : r);
  endtask

  // Stops offering and waits until every owed reply has come back.
  task automatic drain_replies();
    item_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Slot-count write; the block empties the ring on it.
  task automatic write_slots(input logic [BRF_CFG_W-1:0] v);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.ring_slots <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    ring_cfg  = v;
    ring_head = 0;
    ring_tail = 0;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random backpressure, plus one long hold-off on request.
  // ---------------------------------------------------------------------
  initial begin : reply_sink
    int g;
    int calm;
    calm = 0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_wanted && !hold_done) begin
        // sender keeps offering meanwhile, so the block stalls its input
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      g = next_gap(calm);
      if (g > 0) begin
        res_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Checker: each taken reply against the oldest owed one.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : reply_check
    fifo_reply_t got;
    fifo_reply_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = {res_ch.read_byte, res_ch.ok, res_ch.found_offset, res_ch.fill_count,
             res_ch.is_empty, res_ch.is_full};
      if (pending_replies.size() == 0) begin
        fails++;
        if (fails <= MAX_SHOWN)
          $display("[%0t] reply with none owed: rd=%02h ok=%0b fo=%0d fill=%0d e=%0b f=%0b",
                   $realtime, got.read_byte, got.ok, got.found_offset, got.fill_count,
                   got.is_empty, got.is_full);
      end else begin
        want = pending_replies.pop_front();
        replies_seen++;
        if (got !== want) begin
          fails++;
          if (fails <= MAX_SHOWN)
            $display("[%0t] reply %0d: want rd=%02h ok=%0b fo=%0d fill=%0d e=%0b f=%0b, got rd=%02h ok=%0b fo=%0d fill=%0d e=%0b f=%0b",
                     $realtime, replies_seen,
                     want.read_byte, want.ok, want.found_offset, want.fill_count,
                     want.is_empty, want.is_full,
                     got.read_byte, got.ok, got.found_offset, got.fill_count,
                     got.is_empty, got.is_full);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed script, then random phases at several slot counts.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    script_row_t           script [$];
    int                    slot_plan [PLAN_LEN];
    logic [BRF_KIND_W-1:0] k;
    logic [BRF_BYTE_W-1:0] d;
    logic [BRF_OFF_W-1:0]  o;
    int g, tx_calm, phase, sent, n, target_fill, cap;

    item_ch.valid      <= 1'b0;
    item_ch.kind       <= KIND_PUSH;
    item_ch.data_byte  <= '0;
    item_ch.offset     <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.ring_slots  <= '0;
    ring_cfg  = BRF_CFG_W'(BRF_RING_SLOTS_RESET);
    ring_head = 0;
    ring_tail = 0;
    tx_calm   = 0;
    target_fill = 0;
    // extremes first, including values the block clamps
    slot_plan = '{64, 2, 1, 3, 63, 127, 5, 33, 0, 65, 16, 100};

    // Out of reset: 64 slots, capacity 63.
    script.push_back(op_row(KIND_POP,   8'h00, 6'd0,  reply(8'h00, 0, 0, 0, 1, 0)));
    script.push_back(op_row(KIND_PEEK,  8'h00, 6'd0,  reply(8'h00, 0, 0, 0, 1, 0)));
    script.push_back(op_row(KIND_FIND,  8'h00, 6'd0,  reply(8'h00, 0, 0, 0, 1, 0)));
    script.push_back(op_row(KIND_DROP,  8'h00, 6'd63, reply(8'h00, 1, 0, 0, 1, 0)));
    script.push_back(op_row(KIND_PUSH,  8'hFF, 6'd0,  reply(8'h00, 1, 0, 1, 0, 0)));
    script.push_back(op_row(KIND_PUSH,  8'h00, 6'd63, reply(8'h00, 1, 0, 2, 0, 0)));
    script.push_back(op_row(KIND_PEEK,  8'h00, 6'd0,  reply(8'hFF, 1, 0, 2, 0, 0)));
    script.push_back(op_row(KIND_PEEK,  8'hFF, 6'd1,  reply(8'h00, 1, 0, 2, 0, 0)));
    script.push_back(op_row(KIND_PEEK,  8'h00, 6'd2,  reply(8'h00, 0, 0, 2, 0, 0)));
    script.push_back(op_row(KIND_PEEK,  8'h00, 6'd63, reply(8'h00, 0, 0, 2, 0, 0)));
    script.push_back(op_row(KIND_FIND,  8'h00, 6'd0,  reply(8'h00, 1, 1, 2, 0, 0)));
    script.push_back(op_row(KIND_FIND,  8'hAA, 6'd0,  reply(8'h00, 0, 0, 2, 0, 0)));
    script.push_back(op_row(KIND_RSVD6, 8'hFF, 6'd63, reply(8'h00, 0, 0, 2, 0, 0)));
    script.push_back(op_row(KIND_RSVD7, 8'h00, 6'd0,  reply(8'h00, 0, 0, 2, 0, 0)));
    script.push_back(op_row(KIND_CLEAR, 8'h00, 6'd0,  reply(8'h00, 1, 0, 0, 1, 0)));
    script.push_back(op_row(KIND_PUSH,  8'h7E, 6'd0,  reply(8'h00, 1, 0, 1, 0, 0)));
    // Slot count 0 acts as 2 (capacity 1); the write empties the ring.
    script.push_back(cfg_row(7'd0));
    script.push_back(op_row(KIND_POP,   8'h00, 6'd0,  reply(8'h00, 0, 0, 0, 1, 0)));
    script.push_back(op_row(KIND_PUSH,  8'h5A, 6'd0,  reply(8'h00, 1, 0, 1, 0, 1)));
    script.push_back(op_row(KIND_PUSH,  8'hC3, 6'd0,  reply(8'h00, 0, 0, 1, 0, 1)));
    script.push_back(op_row(KIND_FIND,  8'h5A, 6'd0,  reply(8'h00, 1, 0, 1, 0, 1)));
    script.push_back(op_row(KIND_POP,   8'h00, 6'd0,  reply(8'h5A, 1, 0, 0, 1, 0)));
    script.push_back(op_row(KIND_PUSH,  8'h3C, 6'd0,  reply(8'h00, 1, 0, 1, 0, 1)));
    script.push_back(op_row(KIND_DROP,  8'h00, 6'd63, reply(8'h00, 1, 0, 0, 1, 0)));
    // Slot count above the maximum acts as the maximum.
    script.push_back(cfg_row(7'd127));
    script.push_back(op_row(KIND_PUSH,  8'h81, 6'd0,  reply(8'h00, 1, 0, 1, 0, 0)));
    script.push_back(op_row(KIND_POP,   8'h00, 6'd0,  reply(8'h81, 1, 0, 0, 1, 0)));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain_replies();
        write_slots(script[i].slots);
      end else begin
        g = next_gap(tx_calm);
        if (g > 0) begin
          item_ch.valid <= 1'b0;
          repeat (g) @(posedge clk);
        end
        send_request(script[i].kind, script[i].data, script[i].offs, 1'b1, script[i].want);
      end
    end

    // Random phases. Each starts idle with a new slot count; big rings get
    // longer phases so they have time to fill up.
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_replies();
      write_slots(BRF_CFG_W'((phase < PLAN_LEN) ? slot_plan[phase] : $urandom_range(0, 127)));
      cap = ring_slots_eff() - 1;
      n = (cap > 16) ? $urandom_range(140, 240) : $urandom_range(50, 110);
      for (int j = 0; j < n; j++) begin
        if (j % 64 == 0)
          target_fill = ($urandom_range(0, 2) == 0) ? cap : $urandom_range(0, cap);
        // one mid-phase pause with every reply returned
        if (phase == 3 && j == 40) drain_replies();
        // one long receiver hold-off with the sender still busy
        if (phase == 5 && j == 10) hold_wanted = 1'b1;
        g = next_gap(tx_calm);
        if (g > 0) begin
          item_ch.valid <= 1'b0;
          repeat (g) @(posedge clk);
        end
        pick_request(target_fill, k, d, o);
        send_request(k, d, o, 1'b0, '0);
        if (k <= KIND_CLEAR) sent++;
      end
      phase++;
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      fails += pending_replies.size();
      $display("%0d replies never arrived", pending_replies.size());
    end

    $display("covered %0d requests over %0d slot-count writes; ring full on %0d replies",
             replies_seen, cfg_writes, full_seen);
    $display("find hit %0d times, deepest hit at offset %0d; %0d failures",
             finds_hit, deepest_find, fails);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/brf_pkg.sv
rtl/brf_if.sv
rtl/brf_ctrl.sv
rtl/brf_dp.sv
rtl/byte_ring_fifo_with_search_core.sv
bench/tb_top.sv
